@@ rtl/mlfq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types, register codes and defaults shared by the feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int DEF_NUM_LEVELS  = 4;
  localparam int DEF_QUEUE_DEPTH = 64;

  localparam int BQ_W   = 16;
  localparam int AL_W   = 20;
  localparam int PID_W  = 16;
  localparam int LEN_W  = 20;
  localparam int TIME_W = 32;
  localparam int AGE_W  = 21;
  localparam int SUM_W  = 48;
  localparam int CNT_W  = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_QUANTUM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT    = 1'd1;

  localparam logic [BQ_W-1:0] BASE_QUANTUM_RST = 16'd100;
  localparam logic [AL_W-1:0] AGE_LIMIT_RST    = 20'd25;

  localparam logic CMD_ADMIT    = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [PID_W-1:0]  process_id;
    logic [LEN_W-1:0]  burst_length;
    logic [TIME_W-1:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [PID_W-1:0]  job_id;
    logic [1:0]        level;
    logic [LEN_W-1:0]  run_time;
    logic              finished;
    logic              demoted;
    logic              idle;
    logic              accepted;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] end_time;
    logic [SUM_W-1:0]  total_wait;
    logic [CNT_W-1:0]  completed_count;
    logic [SUM_W-1:0]  total_turnaround;
  } out_item_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [LEN_W-1:0]  remaining;
    logic [TIME_W-1:0] arrival;
    logic [LEN_W-1:0]  total_burst;
    logic [AGE_W-1:0]  age;
  } job_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_AGE0,
    S_AGE,
    S_FIN,
    S_TOT,
    S_OUT
  } state_t;

endpackage

@@ rtl/multilevel_feedback_queue_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Feedback queue scheduler with aging of the last level, jobs held in one RAM.
// ----------------------------------------------------------------------------
// All jobs live in one synchronous RAM of NUM_LEVELS * QUEUE_DEPTH entries,
// organized as one circular queue per level. The aging pass of a dispatch
// item reads one last-level entry per cycle and writes it back, or promotes
// it, in the following cycle, through the single read and single write port
// of the job RAM. There is no clearing pass after reset.
module multilevel_feedback_queue_scheduler
  import mlfq_pkg::*;
#(
  parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW    = $clog2(NUM_LEVELS);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE = NUM_LEVELS * QUEUE_DEPTH;
  localparam int AW    = $clog2(STORE);
  localparam int QW    = BQ_W + NUM_LEVELS - 1;
  localparam logic [LW-1:0] LAST = LW'(NUM_LEVELS - 1);
  localparam logic [LW-1:0] PREV = LW'(NUM_LEVELS - 2);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] slot(input logic [LW-1:0] lv, input logic [PW-1:0] pos);
    return AW'(lv) * AW'(QUEUE_DEPTH) + AW'(pos);
  endfunction

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] tail_pos(input logic [PW-1:0] h, input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(c);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return PW'(s);
  endfunction

  // Job RAM.
  job_entry_t mem [STORE];
  job_entry_t mem_q;

  state_t state, state_next;

  logic [BQ_W-1:0]   base_quantum;
  logic [AL_W-1:0]   age_limit;
  logic [PW-1:0]     level_head  [NUM_LEVELS];
  logic [CW-1:0]     level_count [NUM_LEVELS];
  logic [CW-1:0]     resident_jobs;
  logic [TIME_W-1:0] sched_timer;
  logic [SUM_W-1:0]  sum_wait;
  logic [CNT_W-1:0]  done_jobs;
  logic [SUM_W-1:0]  sum_turnaround;

  // Job being dispatched.
  logic [LW-1:0]     cur_lv;
  logic [PID_W-1:0]  cur_pid;
  logic [LEN_W-1:0]  cur_rem;
  logic [TIME_W-1:0] cur_arr;
  logic [LEN_W-1:0]  cur_tot;
  logic [AGE_W-1:0]  cur_age;
  logic [LEN_W-1:0]  run_r;
  logic              done_r;
  logic [TIME_W:0]   need_r;

  // Aging walk.
  logic [CW-1:0]     age_left;
  logic [PW-1:0]     age_rd;
  logic              p_valid;

  // Result under construction.
  logic [PID_W-1:0]  res_pid;
  logic [1:0]        res_level;
  logic [LEN_W-1:0]  res_run;
  logic              res_finished;
  logic              res_demoted;
  logic              res_idle;
  logic              res_accepted;
  logic [TIME_W-1:0] res_wait;

  // Combinational control.
  logic              found;
  logic [LW-1:0]     fnd_lv;
  logic              rd_en;
  logic [AW-1:0]     raddr;
  logic              pop_en;
  logic [LW-1:0]     pop_lv;
  logic              push_req;
  logic [LW-1:0]     push_lv;
  job_entry_t        push_entry;
  logic              push_ok;
  logic              we;
  logic [AW-1:0]     waddr;
  logic              accept;
  logic              admit_ok;
  logic              load_out;
  logic [QW-1:0]     quantum;
  logic              head_done;
  logic [AGE_W-1:0]  new_age;
  logic              promote;
  logic [TIME_W-1:0] end_c;

  always_comb begin
    found  = 1'b0;
    fnd_lv = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (level_count[l] != '0) begin
        found  = 1'b1;
        fnd_lv = LW'(l);
      end
    end
  end

  assign accept    = in_valid && in_ready;
  assign admit_ok  = resident_jobs < FULL;
  assign quantum   = QW'(base_quantum) << cur_lv;
  assign head_done = (cur_lv == LAST) ||
                     ((QW+LEN_W)'(mem_q.remaining) <= (QW+LEN_W)'(quantum));
  assign new_age   = mem_q.age + AGE_W'(run_r);
  assign promote   = new_age >= AGE_W'(age_limit);
  assign end_c     = sched_timer + TIME_W'(run_r);
  assign push_ok   = level_count[push_lv] < FULL;
  assign we        = push_req && push_ok;
  assign waddr     = slot(push_lv, tail_pos(level_head[push_lv], level_count[push_lv]));

  always_comb begin
    state_next = state;
    in_ready   = (state == S_IDLE);
    rd_en      = 1'b0;
    raddr      = slot(fnd_lv, level_head[fnd_lv]);
    pop_en     = 1'b0;
    pop_lv     = cur_lv;
    push_req   = 1'b0;
    push_lv    = '0;
    push_entry = '{pid: in_data.process_id, remaining: in_data.burst_length,
                   arrival: in_data.arrival_time, total_burst: in_data.burst_length,
                   age: '0};
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_ADMIT) begin
            push_req   = admit_ok;
            state_next = S_OUT;
          end else if (found) begin
            rd_en      = 1'b1;
            state_next = S_HEAD;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_HEAD: begin
        // A finishing job leaves its queue before the aging pass.
        pop_en     = head_done;
        state_next = S_AGE0;
      end
      S_AGE0: begin
        state_next = S_AGE;
      end
      S_AGE: begin
        rd_en = age_left != '0;
        raddr = slot(LAST, age_rd);
        if (p_valid) begin
          pop_en     = 1'b1;
          pop_lv     = LAST;
          push_req   = 1'b1;
          push_lv    = promote ? PREV : LAST;
          push_entry = '{pid: mem_q.pid, remaining: mem_q.remaining,
                         arrival: mem_q.arrival, total_burst: mem_q.total_burst,
                         age: promote ? '0 : new_age};
        end
        if (age_left == '0 && !p_valid) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!done_r) begin
          pop_en     = 1'b1;
          push_req   = 1'b1;
          push_lv    = cur_lv + LW'(1);
          push_entry = '{pid: cur_pid, remaining: cur_rem, arrival: cur_arr,
                         total_burst: cur_tot, age: cur_age};
        end
        state_next = S_TOT;
      end
      S_TOT: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        load_out = !out_valid || out_ready;
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_quantum   <= BASE_QUANTUM_RST;
      age_limit      <= AGE_LIMIT_RST;
      resident_jobs  <= '0;
      sched_timer    <= '0;
      sum_wait       <= '0;
      done_jobs      <= '0;
      sum_turnaround <= '0;
      age_left       <= '0;
      p_valid        <= 1'b0;
      out_valid      <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        level_head[l]  <= '0;
        level_count[l] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE_QUANTUM) begin
          base_quantum <= cfg_data[BQ_W-1:0];
        end else if (cfg_index == CFG_AGE_LIMIT) begin
          age_limit <= cfg_data[AL_W-1:0];
        end
      end

      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (pop_en && pop_lv == LW'(l) && level_count[l] != '0) begin
          level_head[l] <= pos_inc(level_head[l]);
          level_count[l] <= level_count[l] - CW'(1)
                            + CW'(we && push_lv == LW'(l));
        end else begin
          level_count[l] <= level_count[l] + CW'(we && push_lv == LW'(l));
        end
      end

      if (state == S_IDLE && accept && in_data.cmd == CMD_ADMIT && admit_ok) begin
        resident_jobs <= resident_jobs + CW'(1);
        // An admit into an empty system lets the clock jump to the arrival.
        if (resident_jobs == '0 && in_data.arrival_time > sched_timer) begin
          sched_timer <= in_data.arrival_time;
        end
      end
      if (state == S_HEAD && head_done && resident_jobs != '0) begin
        resident_jobs <= resident_jobs - CW'(1);
      end

      if (state == S_AGE0) begin
        age_left <= level_count[LAST];
        p_valid  <= 1'b0;
      end else if (state == S_AGE) begin
        if (rd_en) begin
          age_left <= age_left - CW'(1);
        end
        p_valid <= rd_en;
      end

      if (state == S_FIN) begin
        sched_timer <= end_c;
      end

      if (state == S_TOT && done_r) begin
        done_jobs      <= done_jobs + CNT_W'(1);
        sum_wait       <= sum_wait + SUM_W'(res_wait);
        sum_turnaround <= sum_turnaround + SUM_W'(res_wait) + SUM_W'(cur_tot);
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Job RAM ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[raddr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cur_lv       <= fnd_lv;
          res_pid      <= '0;
          res_level    <= '0;
          res_run      <= '0;
          res_finished <= 1'b0;
          res_demoted  <= 1'b0;
          res_idle     <= 1'b0;
          res_accepted <= 1'b0;
          res_wait     <= '0;
          if (in_data.cmd == CMD_ADMIT) begin
            res_pid      <= in_data.process_id;
            res_accepted <= admit_ok;
          end else if (!found) begin
            res_idle <= 1'b1;
          end
        end
      end
      S_HEAD: begin
        cur_pid      <= mem_q.pid;
        cur_arr      <= mem_q.arrival;
        cur_tot      <= mem_q.total_burst;
        cur_age      <= mem_q.age;
        cur_rem      <= head_done ? mem_q.remaining : mem_q.remaining - LEN_W'(quantum);
        run_r        <= head_done ? mem_q.remaining : LEN_W'(quantum);
        done_r       <= head_done;
        res_pid      <= mem_q.pid;
        res_level    <= 2'(cur_lv);
        res_run      <= head_done ? mem_q.remaining : LEN_W'(quantum);
        res_finished <= head_done;
        res_demoted  <= !head_done;
      end
      S_AGE0: begin
        need_r <= (TIME_W+1)'(cur_arr) + (TIME_W+1)'(cur_tot);
        age_rd <= level_head[LAST];
      end
      S_AGE: begin
        if (rd_en) begin
          age_rd <= pos_inc(age_rd);
        end
      end
      S_FIN: begin
        // A job done before arrival plus burst reports no wait.
        if (done_r && (TIME_W+1)'(end_c) >= need_r) begin
          res_wait <= end_c - TIME_W'(need_r);
        end else begin
          res_wait <= '0;
        end
      end
      S_OUT: begin
        if (load_out) begin
          out_data <= '{job_id: res_pid, level: res_level, run_time: res_run,
                        finished: res_finished, demoted: res_demoted, idle: res_idle,
                        accepted: res_accepted, wait_time: res_wait,
                        end_time: sched_timer, total_wait: sum_wait,
                        completed_count: done_jobs, total_turnaround: sum_turnaround};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
